@@ sv/lcgr_pkg.sv @@
// Shared constants and types for the LCG random-in-range block.
// No dependencies; imported by every module of the block.
`default_nettype none

package lcgr_pkg;

  localparam int unsigned STATE_W = 32;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned RAW_W   = 15;
  localparam int unsigned SPAN_W  = VAL_W + 1;
  localparam int unsigned CNT_W   = $clog2(RAW_W);

  localparam logic [STATE_W-1:0] LCG_MUL = 32'd1103515245;
  localparam logic [STATE_W-1:0] LCG_ADD = 32'd12345;
  localparam logic [STATE_W-1:0] SEED_RST = 32'd1;

  // raw draw sits at bits 30..16 of the new state
  localparam int unsigned RAW_LSB = 16;

  typedef struct packed {
    logic              start;
    logic [RAW_W-1:0]  dividend;
    logic [SPAN_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [RAW_W-1:0] remainder;
  } mod_rsp_t;

endpackage

`default_nettype wire

@@ sv/lcg_random_in_range_unit.sv @@
// LCG random draw reduced into [min, max]: top level with sequencer.
// Depends on lcgr_pkg and lcgr_mod_unit.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one word of max/min bounds.
//   Each word advances a 32-bit LCG once and yields one output word on
//   out_valid_o/out_ready_i: value = min + raw mod (max-min+1), fraction
//   = raw draw as Q0.15, range_error when max == min-1 (value = min).
//   If max < min-1 the raw draw is added to min unreduced.
//   Config channel (cfg_valid_i/cfg_ready_o) loads seed_i into the state;
//   it is taken only while the block is idle.
//   Sequence from input accept to out_valid_o: a multiply step, an add
//   step, a start step, 15 remainder steps in the serial unit, its done
//   step and the output load. One word in flight: no new word is taken
//   until the result of the last one is loaded into the output register.
//   in_ready_o is high only while idle; the next word may be accepted while
//   a result waits in the output register.
//   If the receiver stalls, the next result is held back until the output
//   register frees; the output payload stays stable meanwhile.
//   Reset: state = 1, output empty, block idle.
`default_nettype none

module lcg_random_in_range_unit
  import lcgr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [STATE_W-1:0] seed_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [VAL_W-1:0]   max_value_i,
  input  wire logic [VAL_W-1:0]   min_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [VAL_W-1:0]        value_o,
  output logic [RAW_W-1:0]        fraction_o,
  output logic                    range_error_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_START,
    S_WAIT,
    S_FIN
  } state_e;

  state_e            state_q;
  logic [STATE_W-1:0] gen_q;
  logic [STATE_W-1:0] prod_q;
  logic [VAL_W-1:0]   max_q, min_q;
  logic               err_q, neg_q;
  logic [SPAN_W-1:0]  span_q;
  logic [RAW_W-1:0]   rem_q;
  logic               out_valid_q;
  logic [VAL_W-1:0]   value_q;
  logic [RAW_W-1:0]   fraction_q;
  logic               range_error_q;

  logic               in_acc, cfg_acc;
  logic               out_load;
  logic [SPAN_W:0]    span_full;
  logic [RAW_W-1:0]   raw;
  logic [RAW_W-1:0]   offset;
  mod_req_t           mod_req;
  mod_rsp_t           mod_rsp;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_load    = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  // signed 18-bit span, cannot wrap
  assign span_full = {2'b00, max_q} + (SPAN_W+1)'(1) - {2'b00, min_q};
  assign raw       = gen_q[RAW_LSB +: RAW_W];

  always_comb begin
    priority if (err_q) begin
      offset = '0;
    end else if (neg_q) begin
      offset = raw;
    end else begin
      offset = rem_q;
    end
  end

  assign mod_req.start    = (state_q == S_START);
  assign mod_req.dividend = raw;
  assign mod_req.divisor  = span_q;

  lcgr_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gen_q       <= SEED_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cfg_acc) begin
            gen_q <= seed_i;
          end
          if (in_acc) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_ADD;
        end
        S_ADD: begin
          gen_q   <= prod_q + LCG_ADD;
          state_q <= S_START;
        end
        S_START: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (mod_rsp.done) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      max_q <= max_value_i;
      min_q <= min_value_i;
    end
    if (state_q == S_MUL) begin
      prod_q <= gen_q * LCG_MUL;
    end
    if (state_q == S_ADD) begin
      err_q  <= (span_full == '0);
      neg_q  <= span_full[SPAN_W];
      span_q <= span_full[SPAN_W-1:0];
    end
    if (state_q == S_WAIT && mod_rsp.done) begin
      rem_q <= mod_rsp.remainder;
    end
    if (out_load) begin
      value_q       <= min_q + VAL_W'(offset);
      fraction_q    <= raw;
      range_error_q <= err_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign value_o       = value_q;
  assign fraction_o    = fraction_q;
  assign range_error_o = range_error_q;

endmodule

`default_nettype wire

@@ sv/lcgr_mod_unit.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on lcgr_pkg.
`default_nettype none

module lcgr_mod_unit
  import lcgr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mod_req_t req_i,
  output mod_rsp_t      rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [RAW_W-1:0]  rem_q, rem_d;
  logic [RAW_W-1:0]  dvd_q, dvd_d;
  logic [SPAN_W-1:0] div_q, div_d;
  logic [RAW_W:0]    trial;

  // the partial remainder never exceeds the dividend bits consumed so far
  assign trial = {rem_q, dvd_q[RAW_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      if ({1'b0, trial} >= div_q) begin
        rem_d = RAW_W'({1'b0, trial} - div_q);
      end else begin
        rem_d = trial[RAW_W-1:0];
      end
      dvd_d = {dvd_q[RAW_W-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(RAW_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    div_q <= div_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

@@ sv/lcgr_checker.sv @@
// Port-level checks for lcg_random_in_range_unit, bound to the top level.
// Depends on lcgr_pkg.
`default_nettype none

module lcgr_checker
  import lcgr_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               cfg_ready_o,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [VAL_W-1:0]   value_o,
  input wire logic [RAW_W-1:0]   fraction_o,
  input wire logic               range_error_o
);

  // an accepted word keeps the block busy, so it does not take the next word at once
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("block took a second word too early");

  // a result only appears at the end of a busy period
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while idle");

  // no result can show up in the cycle after accepting a word
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result too soon after accept");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o)
      && $stable(fraction_o) && $stable(range_error_o))
    else $error("stalled output word changed");

  // config and input share the idle window
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o == in_ready_o)
    else $error("config ready outside idle");

endmodule

bind lcg_random_in_range_unit lcgr_checker u_lcgr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_ready_o   (cfg_ready_o),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .value_o       (value_o),
  .fraction_o    (fraction_o),
  .range_error_o (range_error_o)
);

`default_nettype wire
